// ----- hw/rtl/gss_pkg.sv -----
// Shared types and constants of the gated step sequencer.
// No dependencies; every other file in hw/rtl refers to it by scoped names.

package gss_pkg;

   localparam int STEP_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int NOTE_W     = 7;
   localparam int DAC_W      = 12;
   localparam int DIGITS_W   = 64;
   localparam int DIGIT_W    = 4;
   localparam int CSR_IDX_W  = 2;

   // step count saturates here
   localparam logic [COUNT_W-1:0] MAX_STEPS = 5'd16;

   // event kinds
   localparam logic EV_NOTE_ON  = 1'b0;
   localparam logic EV_NOTE_OFF = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STEP_DIGITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_NOTE   = 2'd2;

   // register reset values
   localparam logic [DIGITS_W-1:0] RST_STEP_DIGITS = 64'd481174;
   localparam logic [COUNT_W-1:0]  RST_STEP_COUNT  = 5'd5;
   localparam logic [NOTE_W-1:0]   RST_BASE_NOTE   = 7'd60;

   // major-scale intervals by digit
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
   localparam logic [4:0] SCALE_OFFSETS [0:9] = '{
      5'd0, 5'd2, 5'd4, 5'd5, 5'd7, 5'd9, 5'd11, 5'd12, 5'd14, 5'd16
   };
   localparam logic [NOTE_W:0] NOTE_MAX = 8'd127;

   // dac = floor((m*81900 + 396) / 792) = floor((m*2275 + 11) / 22), m = n - 60.
   // m >= 40 already saturates, so m is clamped to 40 first.
   localparam logic [NOTE_W-1:0] DAC_ZERO_NOTE = 7'd60;
   localparam logic [NOTE_W-1:0] DAC_SPAN_CLAMP = 7'd40;
   localparam int DAC_X_W = 17;
   localparam logic [DAC_X_W-1:0] DAC_MUL  = 17'd2275;
   localparam logic [DAC_X_W-1:0] DAC_BIAS = 17'd11;
   // x/22 = (x>>1)/11, and y/11 = (y * ceil(2^20/11)) >> 20 for y < 2^16
   localparam int DAC_RECIP_SHIFT = 20;
   localparam logic [DAC_X_W-1:0] DAC_RECIP = 17'd95326;
   localparam int DAC_Q_W = 13;
   localparam logic [DAC_Q_W-1:0] DAC_MAX = 13'd4095;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic              kind;
      logic [STEP_W-1:0] step;
   } event_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               clear_step;
   } front_cfg_type;

   typedef struct packed {
      logic [DIGITS_W-1:0] digits;
      logic [NOTE_W-1:0]   base;
   } back_cfg_type;

endpackage

// ----- hw/rtl/gated_step_sequencer_cv_top.sv -----
// Top level of the gated step sequencer: configuration registers and the
// front end, queue and back end. Depends on gss_pkg, gss_front, gss_queue, gss_back.
//
//   channel | direction | handshake          | beat carries
//   req     | in        | req_valid/stall    | gate_level
//   rsp     | out       | rsp_valid/stall    | event_kind, note_number, dac_code, step_number
//   csr     | in        | csr_valid/ready    | index, wdata (ready always high)
//
// One gate beat is taken per cycle while req_stall is low; its event, if any, is queued.
// The back end is two registered stages, the second set by the reciprocal multiply
// that forms the DAC code. A 4-entry event queue takes rsp stalls; req_stall rises
// only once it is full. Reset is synchronous and needs no clearing pass.

module gated_step_sequencer_cv_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_gate_level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_event_kind,
   output logic [gss_pkg::NOTE_W-1:0]         rsp_note_number,
   output logic [gss_pkg::DAC_W-1:0]          rsp_dac_code,
   output logic [gss_pkg::STEP_W-1:0]         rsp_step_number,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gss_pkg::DIGITS_W-1:0]       csr_wdata
);

   logic [gss_pkg::DIGITS_W-1:0] digits_ff, digits_in;
   logic [gss_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [gss_pkg::NOTE_W-1:0]   base_ff, base_in;
   logic                         csr_write;

   gss_pkg::front_cfg_type front_cfg;
   gss_pkg::back_cfg_type  back_cfg;
   gss_pkg::event_type     push_event, pop_event;
   logic                   push, pop, q_full, q_valid;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      digits_in = digits_ff;
      count_in  = count_ff;
      base_in   = base_ff;
      if (csr_write) begin
         unique case (csr_index)
            gss_pkg::REG_STEP_DIGITS: digits_in = csr_wdata;
            gss_pkg::REG_STEP_COUNT:  count_in  = csr_wdata[gss_pkg::COUNT_W-1:0];
            gss_pkg::REG_BASE_NOTE:   base_in   = csr_wdata[gss_pkg::NOTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= gss_pkg::RST_STEP_DIGITS;
         count_ff  <= gss_pkg::RST_STEP_COUNT;
         base_ff   <= gss_pkg::RST_BASE_NOTE;
      end else begin
         digits_ff <= digits_in;
         count_ff  <= count_in;
         base_ff   <= base_in;
      end
   end

   assign front_cfg.count = (count_ff > gss_pkg::MAX_STEPS) ? gss_pkg::MAX_STEPS : count_ff;
   assign front_cfg.clear_step = csr_write &&
      (csr_index == gss_pkg::REG_STEP_DIGITS || csr_index == gss_pkg::REG_STEP_COUNT);
   assign back_cfg.digits = digits_ff;
   assign back_cfg.base   = base_ff;

   gss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_gate_level (req_gate_level),
      .req_stall      (req_stall),
      .cfg            (front_cfg),
      .q_full         (q_full),
      .push           (push),
      .push_event     (push_event)
   );

   gss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (q_full),
      .pop        (pop),
      .pop_valid  (q_valid),
      .pop_event  (pop_event)
   );

   gss_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (back_cfg),
      .q_valid         (q_valid),
      .q_event         (pop_event),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_note_number (rsp_note_number),
      .rsp_dac_code    (rsp_dac_code),
      .rsp_step_number (rsp_step_number)
   );

endmodule

// ----- hw/rtl/gss_front.sv -----
// Front end: takes gate beats, tracks the playing note and the current step,
// and pushes note-on / note-off events into the queue. Depends on gss_pkg.

module gss_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_gate_level,
   output logic                  req_stall,
   input  gss_pkg::front_cfg_type cfg,
   input  logic                  q_full,
   output logic                  push,
   output gss_pkg::event_type    push_event
);

   logic                        playing_ff, playing_in;
   logic [gss_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        accept, enabled, note_on, note_off;
   logic [gss_pkg::COUNT_W-1:0] step_plus;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign enabled   = (cfg.count != '0);
   assign note_on   = accept && enabled && req_gate_level && !playing_ff;
   assign note_off  = accept && enabled && !req_gate_level && playing_ff;
   assign step_plus = {1'b0, step_ff} + gss_pkg::COUNT_W'(1);

   always_comb begin
      playing_in = playing_ff;
      step_in    = step_ff;
      if (note_on) begin
         playing_in = 1'b1;
      end
      if (note_off) begin
         playing_in = 1'b0;
         step_in    = (step_plus >= cfg.count) ? '0 : step_plus[gss_pkg::STEP_W-1:0];
      end
      // digit or count write restarts the sequence
      if (cfg.clear_step) begin
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         playing_ff <= playing_in;
         step_ff    <= step_in;
      end
   end

   assign push            = note_on || note_off;
   assign push_event.kind = note_off ? gss_pkg::EV_NOTE_OFF : gss_pkg::EV_NOTE_ON;
   assign push_event.step = step_ff;

   a_off_needs_note: assert property (@(posedge clock) disable iff (reset)
      (push && push_event.kind == gss_pkg::EV_NOTE_OFF) |=> !playing_ff)
      else $error("note-off left a note playing");

endmodule

// ----- hw/rtl/gss_queue.sv -----
// Short event queue between the front end and the back end.
// Depends on gss_pkg for the event type and depth.

module gss_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gss_pkg::event_type push_event,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output gss_pkg::event_type pop_event
);

   gss_pkg::event_type            entries_ff [gss_pkg::QUEUE_DEPTH];
   logic [gss_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [gss_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [gss_pkg::QPTR_W:0]      count_ff, count_in;

   assign full      = (count_ff == (gss_pkg::QPTR_W+1)'(gss_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_event = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + gss_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + gss_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (gss_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (gss_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (gss_pkg::QPTR_W+1)'(gss_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + (gss_pkg::QPTR_W+1)'(1))
      else $error("queue count lost a push");

endmodule

// ----- hw/rtl/gss_back.sv -----
// Back end: turns queued events into note and DAC code over two registered
// stages; the second stage is the result register. Depends on gss_pkg.

module gss_back (
   input  logic                        clock,
   input  logic                        reset,
   input  gss_pkg::back_cfg_type       cfg,
   input  logic                        q_valid,
   input  gss_pkg::event_type          q_event,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_event_kind,
   output logic [gss_pkg::NOTE_W-1:0]  rsp_note_number,
   output logic [gss_pkg::DAC_W-1:0]   rsp_dac_code,
   output logic [gss_pkg::STEP_W-1:0]  rsp_step_number
);

   // stage 1: note lookup and scaled span
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_kind_ff;
   logic [gss_pkg::STEP_W-1:0]    s1_step_ff;
   logic [gss_pkg::NOTE_W-1:0]    s1_note_ff, s1_note_in;
   logic [gss_pkg::DAC_X_W-1:0]   s1_x_ff, s1_x_in;
   // stage 2: result register
   logic                          s2_valid_ff, s2_valid_in;
   logic                          s2_kind_ff;
   logic [gss_pkg::STEP_W-1:0]    s2_step_ff;
   logic [gss_pkg::NOTE_W-1:0]    s2_note_ff;
   logic [gss_pkg::DAC_W-1:0]     s2_dac_ff, s2_dac_in;

   logic                          s1_load, s2_load;
   logic [gss_pkg::DIGIT_W-1:0]   digit_raw, digit;
   logic [4:0]                    offset;
   logic [gss_pkg::NOTE_W:0]      note_sum;
   logic [gss_pkg::NOTE_W-1:0]    span, span_clamped;
   logic [gss_pkg::DAC_X_W-2:0]   half_x;
   logic [2*gss_pkg::DAC_X_W-2:0] recip_prod;
   logic [gss_pkg::DAC_Q_W-1:0]   quot;

   assign s2_load = !s2_valid_ff || !rsp_stall;
   assign s1_load = !s1_valid_ff || s2_load;
   assign pop     = q_valid && s1_load;

   always_comb begin
      digit_raw = cfg.digits[{q_event.step, 2'b00} +: gss_pkg::DIGIT_W];
      digit     = (digit_raw > gss_pkg::DIGIT_MAX) ? gss_pkg::DIGIT_MAX : digit_raw;
      offset    = gss_pkg::SCALE_OFFSETS[digit];
      note_sum  = {1'b0, cfg.base} + {3'b000, offset};
      s1_note_in = (note_sum > gss_pkg::NOTE_MAX) ? gss_pkg::NOTE_MAX[gss_pkg::NOTE_W-1:0]
                                                  : note_sum[gss_pkg::NOTE_W-1:0];
      span = (s1_note_in > gss_pkg::DAC_ZERO_NOTE) ? s1_note_in - gss_pkg::DAC_ZERO_NOTE : '0;
      span_clamped = (span > gss_pkg::DAC_SPAN_CLAMP) ? gss_pkg::DAC_SPAN_CLAMP : span;
      s1_x_in = gss_pkg::DAC_X_W'(span_clamped) * gss_pkg::DAC_MUL + gss_pkg::DAC_BIAS;
   end

   always_comb begin
      half_x     = s1_x_ff[gss_pkg::DAC_X_W-1:1];
      recip_prod = half_x * gss_pkg::DAC_RECIP;
      quot       = recip_prod[gss_pkg::DAC_RECIP_SHIFT +: gss_pkg::DAC_Q_W];
      if (s1_kind_ff == gss_pkg::EV_NOTE_OFF) begin
         s2_dac_in = '0;
      end else if (quot > gss_pkg::DAC_MAX) begin
         s2_dac_in = gss_pkg::DAC_MAX[gss_pkg::DAC_W-1:0];
      end else begin
         s2_dac_in = quot[gss_pkg::DAC_W-1:0];
      end
   end

   assign s1_valid_in = s1_load ? q_valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_kind_ff <= q_event.kind;
         s1_step_ff <= q_event.step;
         s1_note_ff <= s1_note_in;
         s1_x_ff    <= s1_x_in;
      end
      // hold the result while stalled
      if (s2_load) begin
         s2_kind_ff <= s1_kind_ff;
         s2_step_ff <= s1_step_ff;
         s2_note_ff <= s1_note_ff;
         s2_dac_ff  <= s2_dac_in;
      end
   end

   assign rsp_valid       = s2_valid_ff;
   assign rsp_event_kind  = s2_kind_ff;
   assign rsp_note_number = s2_note_ff;
   assign rsp_dac_code    = s2_dac_ff;
   assign rsp_step_number = s2_step_ff;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for gated_step_sequencer_cv_top: gate beats in, note events out.
// Expected events come from a behavioral predictor of the step sequencer kept in this file.
// Depends on gss_pkg and the RTL under hw/rtl.

module testbench;

   localparam int MAX_REPORTS   = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int LIMIT_TIME    = 2_000_000;
   localparam int CV_NUM        = 81900;
   localparam int CV_ROUND      = 396;
   localparam int CV_DEN        = 792;
   localparam logic [gss_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic                       kind;
      logic [gss_pkg::NOTE_W-1:0] note;
      logic [gss_pkg::DAC_W-1:0]  dac;
      logic [gss_pkg::STEP_W-1:0] step;
   } note_event_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_gate_level = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_event_kind;
   logic [gss_pkg::NOTE_W-1:0]       rsp_note_number;
   logic [gss_pkg::DAC_W-1:0]        rsp_dac_code;
   logic [gss_pkg::STEP_W-1:0]       rsp_step_number;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [gss_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [gss_pkg::DIGITS_W-1:0]     csr_wdata = '0;

   // predictor copy of registers and sequencer state
   logic [gss_pkg::DIGITS_W-1:0]     seq_digits  = gss_pkg::RST_STEP_DIGITS;
   logic [gss_pkg::COUNT_W-1:0]      seq_count   = gss_pkg::RST_STEP_COUNT;
   logic [gss_pkg::NOTE_W-1:0]       seq_base    = gss_pkg::RST_BASE_NOTE;
   logic [gss_pkg::STEP_W-1:0]       seq_step    = '0;
   logic                             seq_playing = 1'b0;

   note_event_type                   pending_events[$];
   int                               mismatches = 0;
   int unsigned                      send_idle_pct = 6;
   int unsigned                      rsp_stall_pct = 47;

   gated_step_sequencer_cv_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_gate_level  (req_gate_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_note_number (rsp_note_number),
      .rsp_dac_code    (rsp_dac_code),
      .rsp_step_number (rsp_step_number),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Work out the event one gate beat causes, if any, and queue it.
   task automatic predict_gate_event(input logic gate);
      int                          active_steps;
      int                          pitch;
      int                          cv;
      logic [gss_pkg::DIGIT_W-1:0] digit;
      note_event_type              ev;
      active_steps = (seq_count > gss_pkg::MAX_STEPS) ? int'(gss_pkg::MAX_STEPS)
                                                      : int'(seq_count);
      if (active_steps == 0 || gate == seq_playing) return;
      digit = seq_digits[int'(seq_step)*gss_pkg::DIGIT_W +: gss_pkg::DIGIT_W];
      if (digit > gss_pkg::DIGIT_MAX) digit = gss_pkg::DIGIT_MAX;
      case (digit)
         4'd0: pitch = 0;
         4'd1: pitch = 2;
         4'd2: pitch = 4;
         4'd3: pitch = 5;
         4'd4: pitch = 7;
         4'd5: pitch = 9;
         4'd6: pitch = 11;
         4'd7: pitch = 12;
         4'd8: pitch = 14;
         default: pitch = 16;
      endcase
      pitch = pitch + int'(seq_base);
      if (pitch > int'(gss_pkg::NOTE_MAX)) pitch = int'(gss_pkg::NOTE_MAX);
      ev.note = pitch[gss_pkg::NOTE_W-1:0];
      ev.step = seq_step;
      if (gate) begin
         ev.kind = gss_pkg::EV_NOTE_ON;
         cv = 0;
         if (pitch > int'(gss_pkg::DAC_ZERO_NOTE))
            cv = ((pitch - int'(gss_pkg::DAC_ZERO_NOTE)) * CV_NUM + CV_ROUND) / CV_DEN;
         if (cv > int'(gss_pkg::DAC_MAX)) cv = int'(gss_pkg::DAC_MAX);
         ev.dac = cv[gss_pkg::DAC_W-1:0];
      end else begin
         ev.kind = gss_pkg::EV_NOTE_OFF;
         ev.dac = '0;
         seq_step = gss_pkg::STEP_W'((int'(seq_step) + 1) % active_steps);
      end
      seq_playing = gate;
      pending_events.push_back(ev);
   endtask

   task automatic report_event(input string what, input note_event_type want,
                               input note_event_type seen);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: kind/note/dac/step expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                  $time, what, want.kind, want.note, want.dac, want.step,
                  seen.kind, seen.note, seen.dac, seen.step);
   endtask

   always @(posedge clock) begin : check_events
      note_event_type seen;
      note_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind = rsp_event_kind;
         seen.note = rsp_note_number;
         seen.dac  = rsp_dac_code;
         seen.step = rsp_step_number;
         if (pending_events.size() == 0) begin
            report_event("unexpected event", '0, seen);
         end else begin
            want = pending_events.pop_front();
            if (seen !== want) report_event("event mismatch", want, seen);
         end
      end
   end

   // Hold the sender until every expected event is out and the pipe is empty.
   task automatic drain_events();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_gate(input logic gate);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_gate_level <= gate;
      do @(posedge clock); while (req_stall);
      predict_gate_event(gate);
   endtask

   task automatic write_reg(input logic [gss_pkg::CSR_IDX_W-1:0] index,
                            input logic [gss_pkg::DIGITS_W-1:0] data);
      drain_events();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         gss_pkg::REG_STEP_DIGITS: begin
            seq_digits = data;
            seq_step   = '0;
         end
         gss_pkg::REG_STEP_COUNT: begin
            seq_count = data[gss_pkg::COUNT_W-1:0];
            seq_step  = '0;
         end
         gss_pkg::REG_BASE_NOTE: begin
            seq_base = data[gss_pkg::NOTE_W-1:0];
         end
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Default registers: repeated highs and lows in the middle are ignored.
   task automatic test_default_sequence();
      send_gate(1'b1);
      send_gate(1'b1);
      send_gate(1'b0);
      send_gate(1'b0);
      send_gate(1'b1);
      send_gate(1'b0);
   endtask

   task automatic test_register_extremes();
      // digits above nine clamp, note saturates, DAC saturates, count saturates
      write_reg(gss_pkg::REG_STEP_DIGITS, '1);
      write_reg(gss_pkg::REG_BASE_NOTE,
                {{(gss_pkg::DIGITS_W-gss_pkg::NOTE_W){1'b1}}, 7'd127});
      write_reg(gss_pkg::REG_STEP_COUNT,
                {{(gss_pkg::DIGITS_W-gss_pkg::COUNT_W){1'b0}}, 5'd31});
      send_gate(1'b1);
      send_gate(1'b0);
      // lowest note, zero DAC, single step wraps onto itself
      write_reg(gss_pkg::REG_STEP_DIGITS, '0);
      write_reg(gss_pkg::REG_BASE_NOTE, '0);
      write_reg(gss_pkg::REG_STEP_COUNT,
                {{(gss_pkg::DIGITS_W-gss_pkg::COUNT_W){1'b1}}, 5'd1});
      send_gate(1'b1);
      send_gate(1'b0);
      send_gate(1'b1);
      send_gate(1'b0);
   endtask

   // Zero count freezes everything; a sounding note waits for a nonzero count.
   task automatic test_count_zero();
      write_reg(gss_pkg::REG_STEP_DIGITS, 64'h0000_0000_0000_0842);
      write_reg(gss_pkg::REG_BASE_NOTE, 64'd72);
      write_reg(gss_pkg::REG_STEP_COUNT, 64'd3);
      send_gate(1'b1);
      write_reg(gss_pkg::REG_STEP_COUNT, 64'd0);
      send_gate(1'b0);
      send_gate(1'b1);
      write_reg(gss_pkg::REG_STEP_COUNT, 64'd3);
      send_gate(1'b1);
      send_gate(1'b0);
   endtask

   // Base note writes keep the step; the unused index changes nothing.
   task automatic test_register_side_effects();
      write_reg(gss_pkg::REG_STEP_DIGITS, 64'hFEDC_BA98_7654_3210);
      write_reg(gss_pkg::REG_STEP_COUNT, 64'd16);
      write_reg(gss_pkg::REG_BASE_NOTE, 64'd60);
      send_gate(1'b1);
      send_gate(1'b0);
      write_reg(gss_pkg::REG_BASE_NOTE, 64'd100);
      send_gate(1'b1);
      send_gate(1'b0);
      write_reg(REG_UNUSED, {$urandom, $urandom});
      send_gate(1'b1);
      send_gate(1'b0);
   endtask

   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                                      input int target);
      int                           sent;
      int                           burst;
      int unsigned                  pick;
      logic                         gate;
      logic [gss_pkg::DIGITS_W-1:0] data;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      gate = 1'b0;
      while (sent < target) begin
         if ($urandom_range(0, 1) == 0) begin
            data = {$urandom, $urandom};
            if ($urandom_range(0, 9) == 0) data = '1;
            write_reg(gss_pkg::REG_STEP_DIGITS, data);
         end
         if ($urandom_range(0, 1) == 0) begin
            data = {$urandom, $urandom};
            pick = $urandom_range(0, 19);
            if (pick == 0)
               data[gss_pkg::COUNT_W-1:0] = '0;
            else if (pick == 1)
               data[gss_pkg::COUNT_W-1:0] = gss_pkg::COUNT_W'($urandom_range(17, 31));
            else
               data[gss_pkg::COUNT_W-1:0] = gss_pkg::COUNT_W'($urandom_range(1, 16));
            write_reg(gss_pkg::REG_STEP_COUNT, data);
         end
         if ($urandom_range(0, 1) == 0) begin
            data = {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            if (pick == 0)
               data[gss_pkg::NOTE_W-1:0] = '0;
            else if (pick == 1)
               data[gss_pkg::NOTE_W-1:0] = '1;
            else
               data[gss_pkg::NOTE_W-1:0] = gss_pkg::NOTE_W'($urandom_range(30, 110));
            write_reg(gss_pkg::REG_BASE_NOTE, data);
         end
         if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
         // mostly alternating gate with the odd repeated level as noise
         burst = $urandom_range(30, 90);
         repeat (burst) begin
            if (sent < target) begin
               if ($urandom_range(0, 99) < 80) gate = ~gate;
               send_gate(gate);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_sequence();
      test_register_extremes();
      test_count_zero();
      test_register_side_effects();
      test_random_traffic(6, 47, 584);
      test_random_traffic(47, 6, 583);
      test_random_traffic(0, 0, 583);
      drain_events();
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_TIME);
      $display("testbench failed");
      $finish;
   end

endmodule
